[rtl/raccel_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raccel_pkg: shared types and constants of the rotary encoder decoder
// Count width, direction codes and acceleration level codes.
// ----------------------------------------------------------------------------
package raccel_pkg;

    // width of the internal position counter (8..32)
    localparam int COUNT_WIDTH = 16;
    localparam int WINDOW_W    = 16;
    localparam int TIME_W      = 32;
    localparam int LEVEL_W     = 4;
    localparam int POS_OUT_W   = 16;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [LEVEL_W-1:0]     t_level;
    typedef logic signed [1:0]      t_dir;

    // step direction codes
    localparam t_dir DIR_NONE = 2'sb00;
    localparam t_dir DIR_CW   = 2'sb01;
    localparam t_dir DIR_CCW  = 2'sb11;

    // acceleration levels
    localparam t_level LVL_0  = 4'd0;
    localparam t_level LVL_2  = 4'd2;
    localparam t_level LVL_4  = 4'd4;
    localparam t_level LVL_6  = 4'd6;
    localparam t_level LVL_9  = 4'd9;
    localparam t_level LVL_12 = 4'd12;

    // window reset value in ms
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd100;

    // state handed to the level evaluator
    typedef struct packed {
        t_count pos;    // position after this sample
        t_count base;   // position at window start
        t_level level;  // current level
    } t_eval_in;

endpackage

[rtl/raccel_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raccel_eval: acceleration level evaluation
// Maps the absolute position change over one window to a level.
// ----------------------------------------------------------------------------
module raccel_eval (
    input  raccel_pkg::t_eval_in i_eval,
    output raccel_pkg::t_level   o_level
);

    raccel_pkg::t_count diff;
    raccel_pkg::t_count mag;

    // modular difference, magnitude at full width (most negative stays large)
    always_comb begin
        diff = i_eval.base - i_eval.pos;
        mag  = diff[raccel_pkg::COUNT_WIDTH-1] ? (~diff + raccel_pkg::t_count'(1)) : diff;
    end

    // range lookup, zero and over-range keep the level
    always_comb begin
        priority if (mag == raccel_pkg::t_count'(1)) begin
            o_level = raccel_pkg::LVL_0;
        end else if (mag == raccel_pkg::t_count'(2)) begin
            o_level = raccel_pkg::LVL_2;
        end else if (mag >= raccel_pkg::t_count'(3) && mag <= raccel_pkg::t_count'(4)) begin
            o_level = raccel_pkg::LVL_4;
        end else if (mag >= raccel_pkg::t_count'(5) && mag <= raccel_pkg::t_count'(7)) begin
            o_level = raccel_pkg::LVL_6;
        end else if (mag >= raccel_pkg::t_count'(8) && mag <= raccel_pkg::t_count'(11)) begin
            o_level = raccel_pkg::LVL_9;
        end else if (mag >= raccel_pkg::t_count'(12) && mag <= raccel_pkg::t_count'(20)) begin
            o_level = raccel_pkg::LVL_12;
        end else begin
            o_level = i_eval.level;
        end
    end

endmodule

[rtl/rotary_encoder_accel_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_accel_decoder: quadrature decoder with acceleration
// Decodes steps from line A edges, keeps a position and an accel level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one sample of both
//   encoder lines with its millisecond timestamp. Output channel
//   (o_out_valid / i_out_stall) returns one result per sample: step
//   direction, acceleration level and position.
//   A sample is registered on transfer; once the result register is free,
//   the decode, the window check and the level lookup run and the result
//   register loads. Throughput: one sample per cycle while the receiver
//   does not stall, set by the single evaluation stage that owns the
//   position / window state.
//   Reset (synchronous, active low) clears both stage valids and the
//   decoder state; the window register returns to 100 ms.
//   While the receiver stalls, the result holds; one more sample can wait
//   in the input register, after that o_in_stall rises.
//   i_cfg_we writes the window length; write only while the block is idle.
// ----------------------------------------------------------------------------
module rotary_encoder_accel_decoder (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // configuration
    input  logic                                    i_cfg_we,
    input  logic [raccel_pkg::WINDOW_W-1:0]         i_cfg_data,
    // sample channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic                                    i_line_a,
    input  logic                                    i_line_b,
    input  logic [raccel_pkg::TIME_W-1:0]           i_now_ms,
    // result channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [1:0]                       o_step_direction,
    output logic [raccel_pkg::LEVEL_W-1:0]          o_accel_level,
    output logic signed [raccel_pkg::POS_OUT_W-1:0] o_position_count
);

    // config and state registers
    logic [raccel_pkg::WINDOW_W-1:0] r_win;
    logic                            r_prev_a;
    raccel_pkg::t_count              r_pos;
    raccel_pkg::t_count              r_base;
    logic [raccel_pkg::TIME_W-1:0]   r_start;
    raccel_pkg::t_level              r_level;

    // input stage
    logic                            r_s1_valid;
    logic                            r_s1_a;
    logic                            r_s1_b;
    logic [raccel_pkg::TIME_W-1:0]   r_s1_now;

    // result stage
    logic                            r_out_valid;
    raccel_pkg::t_dir                r_out_dir;
    raccel_pkg::t_level              r_out_level;
    logic signed [raccel_pkg::POS_OUT_W-1:0] r_out_pos;

    logic                            out_free;
    logic                            s1_move;
    logic                            in_xfer;

    raccel_pkg::t_dir                n_dir;
    raccel_pkg::t_count              n_pos;
    logic [raccel_pkg::TIME_W-1:0]   elapsed;
    logic                            win_due;
    raccel_pkg::t_eval_in            eval_in;
    raccel_pkg::t_level              eval_level;
    raccel_pkg::t_level              n_level;

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // step decode on a change of line A
    always_comb begin
        n_dir = raccel_pkg::DIR_NONE;
        if (r_s1_a != r_prev_a) begin
            if (r_s1_a) begin
                if (!r_s1_b) begin
                    n_dir = raccel_pkg::DIR_CCW;
                end
            end else begin
                n_dir = r_s1_b ? raccel_pkg::DIR_CCW : raccel_pkg::DIR_CW;
            end
        end
    end

    // position update
    always_comb begin
        unique case (n_dir)
            raccel_pkg::DIR_CW:  n_pos = r_pos + raccel_pkg::t_count'(1);
            raccel_pkg::DIR_CCW: n_pos = r_pos - raccel_pkg::t_count'(1);
            default:             n_pos = r_pos;
        endcase
    end

    // window check, wrapping subtraction
    assign elapsed = r_s1_now - r_start;
    assign win_due = elapsed > raccel_pkg::TIME_W'(r_win);

    assign eval_in.pos   = n_pos;
    assign eval_in.base  = r_base;
    assign eval_in.level = r_level;

    raccel_eval u_eval (
        .i_eval  (eval_in),
        .o_level (eval_level)
    );

    assign n_level = win_due ? eval_level : r_level;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= raccel_pkg::WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_win <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_a   <= i_line_a;
            r_s1_b   <= i_line_b;
            r_s1_now <= i_now_ms;
        end
    end

    // decoder state, advances with each sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a <= 1'b0;
            r_pos    <= '0;
            r_base   <= '0;
            r_start  <= '0;
            r_level  <= raccel_pkg::LVL_0;
        end else if (s1_move) begin
            r_prev_a <= r_s1_a;
            r_pos    <= n_pos;
            r_level  <= n_level;
            if (win_due) begin
                r_base  <= n_pos;
                r_start <= r_s1_now;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_dir   <= n_dir;
            r_out_level <= n_level;
            r_out_pos   <= raccel_pkg::POS_OUT_W'(signed'(n_pos));
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_step_direction = r_out_dir;
    assign o_accel_level    = r_out_level;
    assign o_position_count = r_out_pos;

    // checks
    a_level_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_level == raccel_pkg::LVL_0 || r_level == raccel_pkg::LVL_2 ||
                        r_level == raccel_pkg::LVL_4 || r_level == raccel_pkg::LVL_6 ||
                        r_level == raccel_pkg::LVL_9 || r_level == raccel_pkg::LVL_12))
        else $error("accel level outside the level set");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with a free stage");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_move |=> ($stable(r_pos) && $stable(r_level) && $stable(r_start)))
        else $error("decoder state moved without a sample");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && n_dir == raccel_pkg::DIR_NONE) |=> $stable(r_pos))
        else $error("position moved without a step");

endmodule
